@@ hdl/column_statistics_aggregator_macros.svh @@
// ----------------------------------------------------------------------------
// column_statistics_aggregator_macros.svh
// Assertion macros used by the checker file of the block.
// ----------------------------------------------------------------------------
`ifndef COLUMN_STATISTICS_AGGREGATOR_MACROS_SVH
`define COLUMN_STATISTICS_AGGREGATOR_MACROS_SVH

// Clocked assertion, switched off while reset is high
`define CSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset
`define CSA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/csa_pkg.sv @@
// ----------------------------------------------------------------------------
// csa_pkg
// Widths, codes and shared types of the column statistics aggregator.
// ----------------------------------------------------------------------------
package csa_pkg;

  // Item field widths (Q8.8 cell values, Q16 variance)
  localparam int VALUE_W = 16;
  localparam int COUNT_W = 17;
  localparam int SUM_W   = 33;
  localparam int SQ_W    = 47;
  localparam int AGG_W   = 33;

  // Row limit of one column group
  localparam logic [COUNT_W-1:0] MAX_ROWS = 17'd65536;

  // Finalize arithmetic
  localparam int MUL_W      = 32;
  localparam int PROD_W     = 64;
  localparam int S2_SPLIT   = 24;
  localparam int DIV_W      = 33;
  localparam int DIV_CNT_W  = 7;
  localparam int ROOT_W     = 32;
  localparam int SQRT_CNT_W = 6;

  // Configuration port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam int FN_W   = 3;

  typedef enum logic {
    REG_FUNCTION_SELECT,
    REG_POPULATION_MODE
  } reg_idx_t;

  typedef enum logic [FN_W-1:0] {
    FN_SUM,
    FN_MEAN,
    FN_MIN,
    FN_MAX,
    FN_COUNT_NONNULL,
    FN_COUNT_ALL,
    FN_VARIANCE,
    FN_STDDEV
  } fn_t;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_RES_DIRECT,
    OP_RES_ZERO,
    OP_MUL1,
    OP_MUL2,
    OP_MUL3,
    OP_MUL4,
    OP_DIV_MEAN,
    OP_DIV_VAR,
    OP_RES_MEAN,
    OP_RES_QUOT,
    OP_SQRT,
    OP_RES_ROOT,
    OP_LOAD
  } dp_op_t;

  typedef struct packed {
    logic   accum;
    dp_op_t op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic n_one;
    logic div_busy;
    logic sqrt_busy;
  } dp_status_t;

endpackage

@@ hdl/csa_if.sv @@
// ----------------------------------------------------------------------------
// csa_if
// Valid/ready channels: column cells in, aggregate results out.
// ----------------------------------------------------------------------------
interface csa_cell_if;
  import csa_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] cell_value;
  logic                      cell_is_null;
  logic                      cell_not_numeric;
  logic                      last_cell;

  modport source (
    output valid, cell_value, cell_is_null, cell_not_numeric, last_cell,
    input  ready
  );
  modport sink (
    input  valid, cell_value, cell_is_null, cell_not_numeric, last_cell,
    output ready
  );
endinterface

interface csa_result_if;
  import csa_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [AGG_W-1:0] aggregate_value;
  logic [COUNT_W-1:0]      numeric_rows;
  logic                    row_overflow;

  modport source (
    output valid, aggregate_value, numeric_rows, row_overflow,
    input  ready
  );
  modport sink (
    input  valid, aggregate_value, numeric_rows, row_overflow,
    output ready
  );
endinterface

@@ hdl/column_statistics_aggregator.sv @@
// ----------------------------------------------------------------------------
// column_statistics_aggregator
// Per-group column statistics (sum, mean, min, max, counts, variance,
// stddev) over a stream of Q8.8 cells, one result per group.
//
//   channel   direction  handshake            payload
//   cells     in         valid/ready          cell_value, flags, last_cell
//   results   out        valid/ready          aggregate_value, numeric_rows,
//                                             row_overflow
//   apb       in         psel/penable/pready  function_select, population_mode
//
// Cells are taken one per cycle while a group accumulates; a result still
// waiting at the output does not stop the next group.
// After the last cell: sum, min, max and counts are loaded directly, mean
// goes through the 64-step divider, variance through the multiplier and the
// divider, stddev also through the 32-step square root. No cell is taken during that time.
// A result that is not taken holds the finalize of the next group in its
// load step. Reset is synchronous and clears the statistics and configuration registers.
// ----------------------------------------------------------------------------
module column_statistics_aggregator (
  input  logic                       clk,
  input  logic                       rst,
  csa_cell_if.sink                   cells,
  csa_result_if.source               results,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [csa_pkg::ADDR_W-1:0] paddr,
  input  logic [csa_pkg::DATA_W-1:0] pwdata,
  output logic [csa_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import csa_pkg::*;

  fn_t        fn_reg;
  logic       pop_reg;
  reg_idx_t   reg_idx;
  ctrl_cmd_t  cmd;
  dp_status_t stat;

  // Configuration registers
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      fn_reg  <= FN_SUM;
      pop_reg <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_FUNCTION_SELECT: fn_reg  <= fn_t'(pwdata[FN_W-1:0]);
        REG_POPULATION_MODE: pop_reg <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FUNCTION_SELECT: prdata = DATA_W'(fn_reg);
      REG_POPULATION_MODE: prdata = DATA_W'(pop_reg);
      default:             prdata = '0;
    endcase
  end

  csa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cells.valid),
    .in_last   (cells.last_cell),
    .in_ready  (cells.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .fn        (fn_reg),
    .pop_mode  (pop_reg),
    .stat      (stat),
    .cmd       (cmd)
  );

  csa_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .fn               (fn_reg),
    .pop_mode         (pop_reg),
    .cell_value       (cells.cell_value),
    .cell_is_null     (cells.cell_is_null),
    .cell_not_numeric (cells.cell_not_numeric),
    .aggregate_value  (results.aggregate_value),
    .numeric_rows     (results.numeric_rows),
    .row_overflow     (results.row_overflow)
  );

endmodule

@@ hdl/csa_div.sv @@
// ----------------------------------------------------------------------------
// csa_div
// Restoring divider, unsigned, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module csa_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [csa_pkg::PROD_W-1:0] dividend,
  input  logic [csa_pkg::DIV_W-1:0]  divisor,
  output logic                       busy,
  output logic [csa_pkg::PROD_W-1:0] quotient
);
  import csa_pkg::*;

  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     dsr;
  logic [PROD_W-1:0]    quo;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W:0]       rem_sh;
  logic [DIV_W:0]       diff;
  logic                 take;

  // Shift in the next dividend bit and trial-subtract
  assign rem_sh = {rem, quo[PROD_W-1]};
  assign diff   = rem_sh - {1'b0, dsr};
  assign take   = ~diff[DIV_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_W'(PROD_W);
      rem  <= '0;
      dsr  <= divisor;
      quo  <= dividend;
    end else if (busy) begin
      rem <= take ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      quo <= {quo[PROD_W-2:0], take};
      cnt <= cnt - 1'b1;
      if (cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign quotient = quo;

endmodule

@@ hdl/csa_sqrt.sv @@
// ----------------------------------------------------------------------------
// csa_sqrt
// Digit-by-digit floor square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module csa_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [csa_pkg::PROD_W-1:0] radicand,
  output logic                       busy,
  output logic [csa_pkg::ROOT_W-1:0] root
);
  import csa_pkg::*;

  localparam int REM_W = ROOT_W + 2;
  localparam int SH_W  = REM_W + 2;

  logic [PROD_W-1:0]     rad;
  logic [REM_W-1:0]      rem;
  logic [SQRT_CNT_W-1:0] cnt;
  logic [SH_W-1:0]       rem_sh;
  logic [SH_W-1:0]       trial;
  logic [SH_W-1:0]       diff;
  logic                  take;

  // Bring down two radicand bits, try root*4+1
  assign rem_sh = {rem, rad[PROD_W-1 -: 2]};
  assign trial  = {2'b00, root, 2'b01};
  assign take   = (rem_sh >= trial);
  assign diff   = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= SQRT_CNT_W'(ROOT_W);
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[PROD_W-3:0], 2'b00};
      rem  <= take ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
      root <= {root[ROOT_W-2:0], take};
      cnt  <= cnt - 1'b1;
      if (cnt == SQRT_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/csa_datapath.sv @@
// ----------------------------------------------------------------------------
// csa_datapath
// Column accumulators, finalize multiplier, divider, square root and the
// result register.
// ----------------------------------------------------------------------------
module csa_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  csa_pkg::ctrl_cmd_t                 cmd,
  output csa_pkg::dp_status_t                stat,
  input  csa_pkg::fn_t                       fn,
  input  logic                               pop_mode,
  input  logic signed [csa_pkg::VALUE_W-1:0] cell_value,
  input  logic                               cell_is_null,
  input  logic                               cell_not_numeric,
  output logic signed [csa_pkg::AGG_W-1:0]   aggregate_value,
  output logic [csa_pkg::COUNT_W-1:0]        numeric_rows,
  output logic                               row_overflow
);
  import csa_pkg::*;

  // Column statistics
  logic [COUNT_W-1:0]        all_cnt;
  logic [COUNT_W-1:0]        nn_cnt;
  logic [COUNT_W-1:0]        num_cnt;
  logic signed [SUM_W-1:0]   val_sum;
  logic [SQ_W-1:0]           sq_sum;
  logic signed [VALUE_W-1:0] run_min;
  logic signed [VALUE_W-1:0] run_max;
  logic                      ovf;

  // Finalize registers
  logic [PROD_W-1:0]         prod;
  logic [PROD_W-1:0]         num_acc;
  logic signed [AGG_W-1:0]   res;

  logic signed [2*VALUE_W-1:0] sq_cell;
  logic                        is_numeric;
  logic                        sum_neg;
  logic [SUM_W-1:0]            sum_abs;
  logic [MUL_W-1:0]            mag;
  logic [COUNT_W-1:0]          den;
  logic [MUL_W-1:0]            mul_a;
  logic [MUL_W-1:0]            mul_b;
  logic [PROD_W-1:0]           mul_p;
  logic                        div_start;
  logic [PROD_W-1:0]           div_dividend;
  logic [DIV_W-1:0]            div_divisor;
  logic [PROD_W-1:0]           div_q;
  logic                        div_busy;
  logic                        sqrt_busy;
  logic [ROOT_W-1:0]           sqrt_root;

  assign sq_cell    = cell_value * cell_value;
  assign is_numeric = ~cell_is_null & ~cell_not_numeric;

  // Magnitude of the sum, and the divisor term n or n-1
  assign sum_neg = val_sum[SUM_W-1];
  assign sum_abs = sum_neg ? SUM_W'(-val_sum) : SUM_W'(val_sum);
  assign mag     = sum_abs[MUL_W-1:0];
  assign den     = pop_mode ? num_cnt : num_cnt - 1'b1;

  // Shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_MUL1: begin
        mul_a = MUL_W'(num_cnt);
        mul_b = MUL_W'(sq_sum[S2_SPLIT-1:0]);
      end
      OP_MUL2: begin
        mul_a = MUL_W'(num_cnt);
        mul_b = MUL_W'(sq_sum[SQ_W-1:S2_SPLIT]);
      end
      OP_MUL3: begin
        mul_a = mag;
        mul_b = mag;
      end
      OP_MUL4: begin
        mul_a = MUL_W'(num_cnt);
        mul_b = MUL_W'(den);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Divider operands: |sum| / n for mean, (n*S2 - S1^2) / (n*d) for variance
  assign div_start    = (cmd.op == OP_DIV_MEAN) || (cmd.op == OP_DIV_VAR);
  assign div_dividend = (cmd.op == OP_DIV_MEAN) ? PROD_W'(mag) : num_acc;
  assign div_divisor  = (cmd.op == OP_DIV_MEAN) ? DIV_W'(num_cnt) : prod[DIV_W-1:0];

  csa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_q)
  );

  csa_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.op == OP_SQRT),
    .radicand (div_q),
    .busy     (sqrt_busy),
    .root     (sqrt_root)
  );

  // Accumulation per accepted cell; cleared when a result is loaded
  always_ff @(posedge clk) begin
    if (rst || (cmd.op == OP_LOAD)) begin
      all_cnt <= '0;
      nn_cnt  <= '0;
      num_cnt <= '0;
      val_sum <= '0;
      sq_sum  <= '0;
      run_min <= '0;
      run_max <= '0;
      ovf     <= 1'b0;
    end else if (cmd.accum) begin
      if (all_cnt >= MAX_ROWS) begin
        ovf <= 1'b1;
      end else begin
        all_cnt <= all_cnt + 1'b1;
        if (!cell_is_null) begin
          nn_cnt <= nn_cnt + 1'b1;
        end
        if (is_numeric) begin
          if ((num_cnt == '0) || (cell_value < run_min)) begin
            run_min <= cell_value;
          end
          if ((num_cnt == '0) || (cell_value > run_max)) begin
            run_max <= cell_value;
          end
          num_cnt <= num_cnt + 1'b1;
          val_sum <= val_sum + SUM_W'(cell_value);
          sq_sum  <= sq_sum + SQ_W'($unsigned(sq_cell));
        end
      end
    end
  end

  // Finalize sequence: products, numerator, result select
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_MUL1: prod <= mul_p;
      OP_MUL2: begin
        prod    <= mul_p;
        num_acc <= prod;
      end
      OP_MUL3: begin
        prod    <= mul_p;
        num_acc <= num_acc + (prod << S2_SPLIT);
      end
      OP_MUL4: begin
        prod    <= mul_p;
        num_acc <= (num_acc < prod) ? '0 : num_acc - prod;
      end
      OP_RES_ZERO: res <= '0;
      OP_RES_DIRECT: begin
        case (fn)
          FN_SUM:           res <= val_sum;
          FN_MIN:           res <= AGG_W'(run_min);
          FN_MAX:           res <= AGG_W'(run_max);
          FN_COUNT_NONNULL: res <= AGG_W'(nn_cnt);
          FN_COUNT_ALL:     res <= AGG_W'(all_cnt);
          default:          res <= '0;
        endcase
      end
      OP_RES_MEAN: res <= sum_neg ? -AGG_W'(div_q) : AGG_W'(div_q);
      OP_RES_QUOT: res <= AGG_W'(div_q);
      OP_RES_ROOT: res <= AGG_W'(sqrt_root);
      default: ;
    endcase
  end

  // Output register, filled as the statistics clear
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      aggregate_value <= res;
      numeric_rows    <= num_cnt;
      row_overflow    <= ovf;
    end
  end

  assign stat.n_zero    = (num_cnt == '0);
  assign stat.n_one     = (num_cnt == COUNT_W'(1));
  assign stat.div_busy  = div_busy;
  assign stat.sqrt_busy = sqrt_busy;

endmodule

@@ hdl/csa_ctrl.sv @@
// ----------------------------------------------------------------------------
// csa_ctrl
// Controller: accepts cells, sequences the finalize steps of a group and
// owns the result valid flag.
// ----------------------------------------------------------------------------
module csa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_last,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  csa_pkg::fn_t        fn,
  input  logic                pop_mode,
  input  csa_pkg::dp_status_t stat,
  output csa_pkg::ctrl_cmd_t  cmd
);
  import csa_pkg::*;

  typedef enum logic [3:0] {
    ST_ACCUM,
    ST_SELECT,
    ST_MUL2,
    ST_MUL3,
    ST_MUL4,
    ST_DIV_VAR,
    ST_DIV_WAIT,
    ST_SQRT_WAIT,
    ST_LOAD
  } state_t;

  state_t state;
  state_t state_next;
  logic   load_go;

  assign in_ready  = (state == ST_ACCUM);
  assign load_go   = (state == ST_LOAD) && (!out_valid || out_ready);

  // Next state and datapath operation
  always_comb begin
    state_next = state;
    cmd.accum  = in_valid && in_ready;
    cmd.op     = OP_NONE;
    case (state)
      ST_ACCUM: begin
        if (in_valid && in_last) begin
          state_next = ST_SELECT;
        end
      end
      ST_SELECT: begin
        case (fn)
          FN_SUM, FN_MIN, FN_MAX: begin
            cmd.op     = stat.n_zero ? OP_RES_ZERO : OP_RES_DIRECT;
            state_next = ST_LOAD;
          end
          FN_COUNT_NONNULL, FN_COUNT_ALL: begin
            cmd.op     = OP_RES_DIRECT;
            state_next = ST_LOAD;
          end
          FN_MEAN: begin
            if (stat.n_zero) begin
              cmd.op     = OP_RES_ZERO;
              state_next = ST_LOAD;
            end else begin
              cmd.op     = OP_DIV_MEAN;
              state_next = ST_DIV_WAIT;
            end
          end
          default: begin
            // Variance and stddev; undefined statistics give zero
            if (stat.n_zero || (!pop_mode && stat.n_one)) begin
              cmd.op     = OP_RES_ZERO;
              state_next = ST_LOAD;
            end else begin
              cmd.op     = OP_MUL1;
              state_next = ST_MUL2;
            end
          end
        endcase
      end
      ST_MUL2: begin
        cmd.op     = OP_MUL2;
        state_next = ST_MUL3;
      end
      ST_MUL3: begin
        cmd.op     = OP_MUL3;
        state_next = ST_MUL4;
      end
      ST_MUL4: begin
        cmd.op     = OP_MUL4;
        state_next = ST_DIV_VAR;
      end
      ST_DIV_VAR: begin
        cmd.op     = OP_DIV_VAR;
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (!stat.div_busy) begin
          if (fn == FN_MEAN) begin
            cmd.op     = OP_RES_MEAN;
            state_next = ST_LOAD;
          end else if (fn == FN_VARIANCE) begin
            cmd.op     = OP_RES_QUOT;
            state_next = ST_LOAD;
          end else begin
            cmd.op     = OP_SQRT;
            state_next = ST_SQRT_WAIT;
          end
        end
      end
      ST_SQRT_WAIT: begin
        if (!stat.sqrt_busy) begin
          cmd.op     = OP_RES_ROOT;
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (load_go) begin
          cmd.op     = OP_LOAD;
          state_next = ST_ACCUM;
        end
      end
      default: state_next = ST_ACCUM;
    endcase
  end

  // State and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ACCUM;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/csa_checker.sv @@
// ----------------------------------------------------------------------------
// csa_checker
// Port-level checks of the column statistics aggregator, bound to the top.
// ----------------------------------------------------------------------------
`include "column_statistics_aggregator_macros.svh"

module csa_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        cells_valid,
  input logic                        cells_ready,
  input logic                        cells_last,
  input logic                        results_valid,
  input logic                        results_ready,
  input logic [csa_pkg::COUNT_W-1:0] results_rows
);
  import csa_pkg::*;

  // No result shows up in the cycle after reset
  `CSA_ASSERT_ALWAYS(a_no_result_after_reset, rst |=> !results_valid, "result valid after reset")

  // A result that is not taken stays offered
  `CSA_ASSERT(a_result_held, results_valid && !results_ready |=> results_valid, "result dropped")

  // The group ends: no cell is taken right after its last cell
  `CSA_ASSERT(a_finalize_stall, cells_valid && cells_ready && cells_last |=> !cells_ready, "cell taken during finalize")

  // Numeric row count never passes the row limit
  `CSA_ASSERT(a_rows_limit, results_valid |-> results_rows <= MAX_ROWS, "numeric rows beyond limit")

endmodule

bind column_statistics_aggregator csa_checker u_csa_checker (
  .clk           (clk),
  .rst           (rst),
  .cells_valid   (cells.valid),
  .cells_ready   (cells.ready),
  .cells_last    (cells.last_cell),
  .results_valid (results.valid),
  .results_ready (results.ready),
  .results_rows  (results.numeric_rows)
);
